// ===== sv/lsfc_pkg.sv =====
// lsfc_pkg: shared types and constants for the segment frustum clipper.
// No dependencies.
package lsfc_pkg;
   localparam int CoordW = 16;
   localparam int DistW  = 36;
   localparam int NumW   = 54;
   localparam int MaxPlanes = 6;
   localparam int CsrIdxW = 3;

   typedef logic signed [CoordW-1:0] coord_type;

   typedef struct packed {
      logic start;
      logic signed [NumW-1:0] num;
      logic [DistW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic signed [CoordW+1:0] quo;
   } div_rsp_type;
endpackage

// ===== sv/line_segment_frustum_clip_top.sv =====
// line_segment_frustum_clip_top: plane loop sequencer with shared MAC and divider.
// Depends on lsfc_pkg, lsfc_div.
//  channel | dir | handshake        | payload
//  req     | in  | req_valid/ready  | start_xyz, end_xyz
//  rsp     | out | rsp_valid/ready  | culled, out_start_xyz, out_end_xyz
//  csr     | in  | csr_write_enable | csr_index, csr_data (64 bits)
// Per plane: MAC steps over both endpoints, then a decide step; a crossing plane adds,
// for each axis, multiply steps on the two halves of d1 and a divider run, then another
// decide step. Sync reset clears control state and the plane registers only.
// req_ready is low from accept until the result word is taken.
module line_segment_frustum_clip_top #(
   parameter int NUM_PLANES = 6
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  lsfc_pkg::coord_type req_start_x, req_start_y, req_start_z,
   input  lsfc_pkg::coord_type req_end_x, req_end_y, req_end_z,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_culled,
   output lsfc_pkg::coord_type rsp_out_start_x, rsp_out_start_y, rsp_out_start_z,
   output lsfc_pkg::coord_type rsp_out_end_x, rsp_out_end_y, rsp_out_end_z,
   input  logic csr_write_enable,
   input  logic [lsfc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [63:0] csr_data
);
   localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
   localparam logic [2:0] S_IDLE = 3'd0, S_MAC = 3'd1, S_DEC = 3'd2,
      S_MUL = 3'd3, S_DIV = 3'd4, S_OUT = 3'd5;
   localparam int DW = lsfc_pkg::DistW;

   logic [63:0] planes_ff [NUM_PLANES];
   logic [2:0] st_ff, st_in;
   logic [PW-1:0] pl_ff, pl_in;
   logic [2:0] step_ff, step_in;
   logic [1:0] ax_ff, ax_in;
   lsfc_pkg::coord_type a_ff [3], a_in [3], b_ff [3], b_in [3];
   logic signed [DW-1:0] d1_ff, d1_in, d2_ff, d2_in, acc;
   logic signed [lsfc_pkg::NumW-1:0] prod_ff, prod_in, psum;
   logic culled_ff, culled_in;
   logic [63:0] pw;
   logic signed [18:0] ma, mb;
   logic signed [37:0] mp;
   logic signed [DW-1:0] den;
   logic signed [16:0] diff;
   lsfc_pkg::div_req_type dreq;
   lsfc_pkg::div_rsp_type drsp;
   lsfc_pkg::coord_type hit;

   lsfc_div u_div (.clock, .reset, .req(dreq), .rsp(drsp));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) planes_ff[i] <= '0;
      end else if (csr_write_enable && csr_index < lsfc_pkg::CsrIdxW'(NUM_PLANES)) begin
         planes_ff[csr_index[PW-1:0]] <= csr_data;
      end
   end

   assign pw = planes_ff[pl_ff];
   // step: 0..2 start xyz, 3 d, 4..6 end xyz, 7 d
   // in S_MUL: step 0 diff * low 18 bits of d1, step 1 diff * high part
   always_comb begin
      case (step_ff)
         3'd0: begin ma = 19'(signed'(pw[15:0]));  mb = 19'(a_ff[0]); end
         3'd1: begin ma = 19'(signed'(pw[31:16])); mb = 19'(a_ff[1]); end
         3'd2: begin ma = 19'(signed'(pw[47:32])); mb = 19'(a_ff[2]); end
         3'd4: begin ma = 19'(signed'(pw[15:0]));  mb = 19'(b_ff[0]); end
         3'd5: begin ma = 19'(signed'(pw[31:16])); mb = 19'(b_ff[1]); end
         3'd6: begin ma = 19'(signed'(pw[47:32])); mb = 19'(b_ff[2]); end
         default: begin ma = 19'(signed'(pw[63:48])); mb = 19'sd16384; end
      endcase
      if (st_ff == S_MUL) begin
         ma = 19'(diff);
         mb = step_ff[0] ? 19'(signed'(d1_ff[DW-1:18]))
                         : 19'(signed'({1'b0, d1_ff[17:0]}));
      end
   end
   assign diff = 17'(b_ff[ax_ff]) - 17'(a_ff[ax_ff]);
   assign den = (d1_ff - d2_ff) < 0 ? d2_ff - d1_ff : d1_ff - d2_ff;
   assign mp = ma * mb;
   assign acc = ((step_ff < 3'd4) ? d1_ff : d2_ff) + DW'(mp);
   assign psum = prod_ff + (lsfc_pkg::NumW'(mp) <<< 18);
   assign hit = lsfc_pkg::CoordW'(18'(a_ff[ax_ff]) + drsp.quo);

   always_comb begin
      st_in = st_ff; pl_in = pl_ff; step_in = step_ff; ax_in = ax_ff;
      a_in = a_ff; b_in = b_ff; d1_in = d1_ff; d2_in = d2_ff;
      prod_in = prod_ff; culled_in = culled_ff;
      dreq.start = 1'b0;
      dreq.num = prod_ff;
      dreq.den = den[DW-1:0];
      case (st_ff)
         S_IDLE: if (req_valid) begin
            a_in[0] = req_start_x; a_in[1] = req_start_y; a_in[2] = req_start_z;
            b_in[0] = req_end_x; b_in[1] = req_end_y; b_in[2] = req_end_z;
            culled_in = 1'b0; pl_in = '0; step_in = '0;
            d1_in = '0; d2_in = '0; st_in = S_MAC;
         end
         S_MAC: begin
            if (step_ff < 3'd4) d1_in = acc; else d2_in = acc;
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd7) st_in = S_DEC;
         end
         S_DEC: begin
            ax_in = '0;
            if (!d1_ff[DW-1] && !d2_ff[DW-1]) begin
               if (pl_ff == PW'(NUM_PLANES - 1)) st_in = S_OUT;
               else begin
                  pl_in = pl_ff + 1'b1; step_in = '0; d1_in = '0; d2_in = '0;
                  st_in = S_MAC;
               end
            end else if (d1_ff[DW-1] && d2_ff[DW-1]) begin
               culled_in = 1'b1; st_in = S_OUT;
            end else begin
               step_in = '0; st_in = S_MUL;
            end
         end
         S_MUL: begin
            // diff*d1 in two halves of d1; sign folded to make den positive
            if (!step_ff[0]) begin
               prod_in = lsfc_pkg::NumW'(mp);
               step_in = 3'd1;
            end else begin
               prod_in = ((d1_ff - d2_ff) < 0) ? -psum : psum;
               st_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!drsp.busy && !drsp.done) dreq.start = 1'b1;
            if (drsp.done) begin
               ax_in = ax_ff + 1'b1;
               step_in = '0;
               // outside endpoint is replaced one axis at a time
               if (d1_ff[DW-1]) a_in[ax_ff] = hit; else b_in[ax_ff] = hit;
               st_in = (ax_ff == 2'd2) ? S_DEC : S_MUL;
               if (ax_ff == 2'd2) begin
                  d1_in = '0; d2_in = '0;
               end
            end
         end
         S_OUT: if (rsp_ready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; d1_ff <= d1_in; d2_ff <= d2_in;
      prod_ff <= prod_in; culled_ff <= culled_in; ax_ff <= ax_in;
      step_ff <= step_in; pl_ff <= pl_in;
      if (reset) st_ff <= S_IDLE;
      else st_ff <= st_in;
   end

   assign req_ready = st_ff == S_IDLE;
   assign rsp_valid = st_ff == S_OUT;
   assign rsp_culled = culled_ff;
   assign rsp_out_start_x = culled_ff ? '0 : a_ff[0];
   assign rsp_out_start_y = culled_ff ? '0 : a_ff[1];
   assign rsp_out_start_z = culled_ff ? '0 : a_ff[2];
   assign rsp_out_end_x = culled_ff ? '0 : b_ff[0];
   assign rsp_out_end_y = culled_ff ? '0 : b_ff[1];
   assign rsp_out_end_z = culled_ff ? '0 : b_ff[2];
endmodule

// ===== sv/lsfc_div.sv =====
// lsfc_div: restoring divider, one quotient bit per cycle, rounds to nearest.
// Depends on lsfc_pkg.
module lsfc_div (
   input  logic clock,
   input  logic reset,
   input  lsfc_pkg::div_req_type req,
   output lsfc_pkg::div_rsp_type rsp
);
   localparam int QW = lsfc_pkg::CoordW + 1;
   localparam int RW = lsfc_pkg::DistW + 1;
   localparam int CW = $clog2(lsfc_pkg::NumW + 1);

   logic [lsfc_pkg::NumW-1:0] mag_ff, mag_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [QW:0] q_ff, q_in;
   logic [lsfc_pkg::DistW-1:0] den_ff, den_in;
   logic neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] trial, sub;
   logic [QW:0] qr;

   always_comb begin
      mag_in = mag_ff; rem_in = rem_ff; q_in = q_ff; den_in = den_ff;
      neg_in = neg_ff; busy_in = busy_ff; cnt_in = cnt_ff; done_in = 1'b0;
      trial = {rem_ff[RW-2:0], mag_ff[lsfc_pkg::NumW-1]};
      sub = trial - {1'b0, den_ff};
      if (req.start) begin
         neg_in = req.num[lsfc_pkg::NumW-1];
         // magnitude times two for the half-step rounding bit
         mag_in = (neg_in ? -req.num : req.num) << 1;
         den_in = req.den;
         rem_in = '0; q_in = '0;
         cnt_in = CW'(lsfc_pkg::NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         mag_in = mag_ff << 1;
         if (!sub[RW-1]) begin
            rem_in = sub; q_in = {q_ff[QW-1:0], 1'b1};
         end else begin
            rem_in = trial; q_in = {q_ff[QW-1:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in; rem_ff <= rem_in; q_ff <= q_in; den_ff <= den_in;
      neg_ff <= neg_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign qr = (q_ff + 1'b1) >> 1;
   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo = neg_ff ? -$signed(qr[QW:0]) : $signed(qr[QW:0]);
endmodule

// ===== sv/lsfc_checker.sv =====
// lsfc_checker: port-level properties of the clipper, bound to the top level.
// Depends on line_segment_frustum_clip_top.
module lsfc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_culled,
   input logic [15:0] rsp_out_start_x
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_nodbl: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("second word taken");
   a_cull0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_culled |-> rsp_out_start_x == 16'h0) else $error("culled data");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
endmodule

bind line_segment_frustum_clip_top lsfc_checker u_lsfc_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_culled, .rsp_out_start_x
);

// ===== bench/tb_line_segment_frustum_clip_top.sv =====
// tb_line_segment_frustum_clip_top: self-checking bench for the segment frustum clipper.
// Predicts each clipped segment from the plane registers and compares result words in order.
// Depends on lsfc_pkg and line_segment_frustum_clip_top.
`timescale 1ns / 100ps

module tb_line_segment_frustum_clip_top;
   localparam int NumPlanes = 6;
   localparam int IdxPlane0 = 0;
   localparam int IdxBad = 7;

   typedef struct packed {
      lsfc_pkg::coord_type sx, sy, sz, ex, ey, ez;
   } segment_type;

   typedef struct packed {
      logic culled;
      lsfc_pkg::coord_type sx, sy, sz, ex, ey, ez;
   } clip_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   lsfc_pkg::coord_type req_start_x = '0, req_start_y = '0, req_start_z = '0;
   lsfc_pkg::coord_type req_end_x = '0, req_end_y = '0, req_end_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_culled;
   lsfc_pkg::coord_type rsp_out_start_x, rsp_out_start_y, rsp_out_start_z;
   lsfc_pkg::coord_type rsp_out_end_x, rsp_out_end_y, rsp_out_end_z;
   logic csr_write_enable = 1'b0;
   logic [lsfc_pkg::CsrIdxW-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   logic [63:0] plane_regs [NumPlanes];
   segment_type pending_segs[$];
   clip_type expected_clips[$];
   int mismatch_count = 0;
   int driver_gap = 0;
   int monitor_gap = 0;
   int accept_count = 0;
   int seen_accepts = 0;

   line_segment_frustum_clip_top #(.NUM_PLANES(NumPlanes)) i_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic signed [63:0] plane_distance(logic [63:0] pl,
         logic signed [63:0] x, logic signed [63:0] y, logic signed [63:0] z);
      logic signed [63:0] nx, ny, nz, d;
      nx = {{48{pl[15]}}, pl[15:0]};
      ny = {{48{pl[31]}}, pl[31:16]};
      nz = {{48{pl[47]}}, pl[47:32]};
      d = {{48{pl[63]}}, pl[63:48]};
      return nx * x + ny * y + nz * z + d * 64'sd16384;
   endfunction

   function automatic logic signed [63:0] round_div(logic signed [63:0] num,
         logic signed [63:0] den);
      logic signed [63:0] mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic clip_type clip_segment(segment_type s);
      logic signed [63:0] a[3], b[3], hit[3];
      logic signed [63:0] d1, d2, num, den;
      clip_type r;
      bit cull;
      cull = 1'b0;
      a[0] = s.sx; a[1] = s.sy; a[2] = s.sz;
      b[0] = s.ex; b[1] = s.ey; b[2] = s.ez;
      for (int i = 0; i < NumPlanes; i++) begin
         d1 = plane_distance(plane_regs[i], a[0], a[1], a[2]);
         d2 = plane_distance(plane_regs[i], b[0], b[1], b[2]);
         if (d1 >= 0 && d2 >= 0) continue;
         if (d1 < 0 && d2 < 0) begin
            cull = 1'b1;
            break;
         end
         num = d1;
         den = d1 - d2;
         if (den < 0) begin
            den = -den;
            num = -num;
         end
         for (int k = 0; k < 3; k++) hit[k] = a[k] + round_div((b[k] - a[k]) * num, den);
         for (int k = 0; k < 3; k++) begin
            if (d1 < 0) a[k] = hit[k];
            else b[k] = hit[k];
         end
      end
      r.culled = cull;
      r.sx = cull ? '0 : a[0][15:0]; r.sy = cull ? '0 : a[1][15:0];
      r.sz = cull ? '0 : a[2][15:0]; r.ex = cull ? '0 : b[0][15:0];
      r.ey = cull ? '0 : b[1][15:0]; r.ez = cull ? '0 : b[2][15:0];
      return r;
   endfunction

   function automatic int random_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // driver: words go out from the pending queue; valid holds until accepted
   always @(negedge clock) begin
      bit hold;
      if (!reset) begin
         hold = req_valid && (accept_count == seen_accepts);
         if (accept_count != seen_accepts) begin
            seen_accepts = accept_count;
            driver_gap = random_gap();
         end
         if (!hold) begin
            if (driver_gap > 0) begin
               driver_gap--;
               req_valid <= 1'b0;
            end else if (pending_segs.size() > 0) begin
               req_valid <= 1'b1;
               {req_start_x, req_start_y, req_start_z, req_end_x, req_end_y, req_end_z}
                  <= pending_segs[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (monitor_gap > 0) begin
            monitor_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) monitor_gap = random_gap();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      clip_type got, want;
      if (!reset && req_valid && req_ready) begin
         expected_clips.insert(expected_clips.size(),
            clip_segment({req_start_x, req_start_y, req_start_z,
               req_end_x, req_end_y, req_end_z}));
         void'(pending_segs.pop_front());
         accept_count++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_culled, rsp_out_start_x, rsp_out_start_y, rsp_out_start_z,
            rsp_out_end_x, rsp_out_end_y, rsp_out_end_z};
         if (expected_clips.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result word %h", got);
         end else begin
            want = expected_clips.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected c=%0b s=%0d,%0d,%0d e=%0d,%0d,%0d",
                     " got c=%0b s=%0d,%0d,%0d e=%0d,%0d,%0d"},
                     want.culled, want.sx, want.sy, want.sz, want.ex, want.ey, want.ez,
                     got.culled, got.sx, got.sy, got.sz, got.ex, got.ey, got.ez);
            end
         end
      end
   end

   task automatic write_plane(int idx, logic [63:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx[lsfc_pkg::CsrIdxW-1:0];
      csr_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx < NumPlanes) plane_regs[idx] = value;
   endtask

   task automatic drain_segments();
      while (pending_segs.size() > 0 || req_valid || expected_clips.size() > 0)
         @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   function automatic lsfc_pkg::coord_type random_coord();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return '0;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [63:0] random_plane();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      if ($urandom_range(0, 1)) begin
         // moderate plane so that crossings are common
         v[15:0] = 16'($urandom_range(0, 32767) - 16384);
         v[31:16] = 16'($urandom_range(0, 32767) - 16384);
         v[47:32] = 16'($urandom_range(0, 32767) - 16384);
         v[63:48] = 16'($urandom_range(0, 8191) - 4096);
      end
      return v;
   endfunction

   task automatic push_segment(lsfc_pkg::coord_type sx, sy, sz, ex, ey, ez);
      pending_segs.insert(pending_segs.size(), segment_type'({sx, sy, sz, ex, ey, ez}));
   endtask

   initial begin
      for (int i = 0; i < NumPlanes; i++) plane_regs[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // all planes zero: everything passes
      push_segment(16'sh7fff, 16'sh8000, '0, 16'sh8000, 16'sh7fff, 16'sh7fff);
      push_segment('0, '0, '0, '0, '0, '0);
      drain_segments();

      // x >= 0 and x <= 4096, plus extremes of the plane fields
      write_plane(IdxPlane0, {16'sh0000, 16'h0000, 16'h0000, 16'h4000});
      write_plane(IdxPlane0 + 1, {16'sh1000, 16'h0000, 16'h0000, 16'hc000});
      write_plane(IdxPlane0 + 2, {16'sh8000, 16'h7fff, 16'h8000, 16'h0000});
      write_plane(IdxPlane0 + 3, 64'h0);
      write_plane(IdxPlane0 + 4, 64'hffff_ffff_ffff_ffff);
      write_plane(IdxPlane0 + 5, {16'sh7fff, 16'h0000, 16'h0000, 16'h0000});
      write_plane(IdxBad, 64'h8000_8000_8000_8000);
      push_segment(16'sh0100, '0, '0, 16'sh0200, '0, '0);
      push_segment(-16'sh0100, '0, '0, -16'sh0200, '0, '0);
      push_segment(-16'sh0100, '0, '0, 16'sh0100, '0, '0);
      push_segment(16'sh0100, 16'sh7fff, '0, -16'sh0100, 16'sh8000, '0);
      push_segment(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      push_segment(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
      push_segment('0, '0, '0, 16'sh2000, 16'sh0100, -16'sh0100);
      push_segment(16'sh0003, 16'sh0001, 16'sh0001, -16'sh0001, '0, '0);
      drain_segments();

      for (int phase = 0; phase < 9; phase++) begin
         for (int i = 0; i < NumPlanes; i++) begin
            if (phase == 8) write_plane(i, 64'h0);
            else write_plane(i, random_plane());
         end
         for (int n = 0; n < 100; n++) begin
            push_segment(random_coord(), random_coord(), random_coord(),
               random_coord(), random_coord(), random_coord());
            if (n == 50) begin
               // hold off until the pipe is empty
               while (pending_segs.size() > 0 || req_valid || expected_clips.size() > 0)
                  @(posedge clock);
            end
         end
         drain_segments();
      end
      if (mismatch_count == 0 && expected_clips.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #25000000;
      $display("FAILURE");
      $finish;
   end
endmodule
